// File: rtl/bfi_pkg.sv
// ----------------------------------------------------------------------------
// bfi_pkg
// Shared types and codes of the Brainfuck interpreter core: item actions,
// instruction bytes, run status and the result record.
// ----------------------------------------------------------------------------
package bfi_pkg;

    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_RESTART = 2'd1;
    localparam logic [1:0] ACT_STEP    = 2'd2;

    localparam logic [7:0] OP_RIGHT = 8'h3E;
    localparam logic [7:0] OP_LEFT  = 8'h3C;
    localparam logic [7:0] OP_INC   = 8'h2B;
    localparam logic [7:0] OP_DEC   = 8'h2D;
    localparam logic [7:0] OP_IN    = 8'h2C;
    localparam logic [7:0] OP_OUT   = 8'h2E;
    localparam logic [7:0] OP_OPEN  = 8'h5B;
    localparam logic [7:0] OP_CLOSE = 8'h5D;

    localparam int LEN_W = 12;

    typedef enum logic [2:0] {
        ST_RUN       = 3'd0,
        ST_DONE      = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_UNMATCHED = 3'd3,
        ST_RANGE     = 3'd4
    } status_t;

    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic       input_used;
        status_t    status;
    } result_t;

endpackage

// File: rtl/bfi_ram.sv
// ----------------------------------------------------------------------------
// bfi_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// read enable and registered read data.
// ----------------------------------------------------------------------------
module bfi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/bfi_seq.sv
// ----------------------------------------------------------------------------
// bfi_seq
// Instruction sequencer: accepts items, drives the program, tape and stack
// memories, executes one instruction per step, scans forward over skipped
// loops, clears the tape after reset and restart, and holds the result.
// ----------------------------------------------------------------------------
module bfi_seq #(
    parameter int PROGRAM_DEPTH = 2048,
    parameter int TAPE_DEPTH    = 1024,
    parameter int STACK_DEPTH   = 1024,
    parameter int PA_W          = $clog2(PROGRAM_DEPTH),
    parameter int PC_W          = $clog2(PROGRAM_DEPTH + 1),
    parameter int DP_W          = $clog2(TAPE_DEPTH),
    parameter int SA_W          = $clog2(STACK_DEPTH),
    parameter int SD_W          = $clog2(STACK_DEPTH + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              action,
    input  logic [10:0]             load_address,
    input  logic [7:0]              data_byte,
    input  logic                    cfg_wen,
    input  logic [bfi_pkg::LEN_W-1:0] cfg_wdata,
    output logic                    result_valid,
    input  logic                    result_ready,
    output bfi_pkg::result_t        result,
    output logic                    prog_we,
    output logic [PA_W-1:0]         prog_waddr,
    output logic [7:0]              prog_wdata,
    output logic                    prog_re,
    output logic [PA_W-1:0]         prog_raddr,
    input  logic [7:0]              prog_rdata,
    output logic                    tape_we,
    output logic [DP_W-1:0]         tape_waddr,
    output logic [7:0]              tape_wdata,
    output logic                    tape_re,
    output logic [DP_W-1:0]         tape_raddr,
    input  logic [7:0]              tape_rdata,
    output logic                    stack_we,
    output logic [SA_W-1:0]         stack_waddr,
    output logic [PC_W-1:0]         stack_wdata,
    output logic                    stack_re,
    output logic [SA_W-1:0]         stack_raddr,
    input  logic [PC_W-1:0]         stack_rdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } state_t;

    state_t                      state_reg, state_next;
    logic [PC_W-1:0]             pc_reg, pc_next;
    logic [DP_W-1:0]             dp_reg, dp_next;
    logic [SD_W-1:0]             depth_reg, depth_next;
    bfi_pkg::status_t            run_status_reg, run_status_next;
    logic [bfi_pkg::LEN_W-1:0]   len_reg, len_next;
    logic [1:0]                  act_reg, act_next;
    logic [7:0]                  din_reg, din_next;
    logic [PC_W-1:0]             scan_p_reg, scan_p_next;
    logic [PC_W-1:0]             nest_reg, nest_next;
    logic                        clr_active_reg, clr_active_next;
    logic [DP_W-1:0]             clr_addr_reg, clr_addr_next;
    logic                        res_valid_reg, res_valid_next;
    bfi_pkg::result_t            res_reg, res_next;

    logic                        in_fire;
    logic                        res_free;
    logic                        res_load;
    bfi_pkg::result_t            res_data;
    logic [PC_W-1:0]             prog_end;
    logic                        pc_at_end;
    logic [PC_W-1:0]             pc_plus;
    logic                        exec_tape_we;
    logic [7:0]                  exec_tape_val;
    logic                        step_fire;

    assign in_ready  = (state_reg == S_IDLE) && !clr_active_reg;
    assign in_fire   = in_valid && in_ready;
    assign step_fire = in_fire && (action == bfi_pkg::ACT_STEP);
    assign res_free  = !res_valid_reg || result_ready;
    assign pc_plus   = pc_reg + PC_W'(1);

    always_comb
    begin
        if ({20'd0, len_reg} < 32'(PROGRAM_DEPTH))
        begin
            prog_end = PC_W'(len_reg);
        end
        else
        begin
            prog_end = PC_W'(PROGRAM_DEPTH);
        end
    end

    assign pc_at_end = (pc_reg >= prog_end) || (prog_rdata == 8'd0);

    always_comb
    begin
        state_next      = state_reg;
        pc_next         = pc_reg;
        dp_next         = dp_reg;
        depth_next      = depth_reg;
        run_status_next = run_status_reg;
        len_next        = cfg_wen ? cfg_wdata : len_reg;
        act_next        = act_reg;
        din_next        = din_reg;
        scan_p_next     = scan_p_reg;
        nest_next       = nest_reg;
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        res_load        = 1'b0;
        res_data        = '{out_valid: 1'b0, out_byte: 8'd0, input_used: 1'b0,
                            status: run_status_reg};
        prog_re         = 1'b0;
        exec_tape_we    = 1'b0;
        exec_tape_val   = 8'd0;
        stack_we        = 1'b0;

        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + DP_W'(1);
            if (clr_addr_reg == DP_W'(TAPE_DEPTH - 1))
            begin
                clr_active_next = 1'b0;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    act_next   = action;
                    din_next   = data_byte;
                    state_next = S_EXEC;
                    prog_re    = step_fire;
                end
            end
            S_EXEC:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                    res_load   = 1'b1;
                    unique case (act_reg)
                        bfi_pkg::ACT_RESTART:
                        begin
                            pc_next         = '0;
                            dp_next         = '0;
                            depth_next      = '0;
                            run_status_next = bfi_pkg::ST_RUN;
                            clr_active_next = 1'b1;
                            clr_addr_next   = '0;
                        end
                        bfi_pkg::ACT_STEP:
                        begin
                            if (run_status_reg == bfi_pkg::ST_RUN)
                            begin
                                if (pc_at_end)
                                begin
                                    run_status_next = bfi_pkg::ST_DONE;
                                end
                                else
                                begin
                                    pc_next = pc_plus;
                                    unique case (prog_rdata)
                                        bfi_pkg::OP_OPEN:
                                        begin
                                            if (tape_rdata != 8'd0)
                                            begin
                                                stack_we   = 1'b1;
                                                depth_next = depth_reg + SD_W'(1);
                                                if (32'(depth_reg) + 32'd1 >= 32'(STACK_DEPTH))
                                                begin
                                                    run_status_next = bfi_pkg::ST_OVERFLOW;
                                                    pc_next         = pc_reg;
                                                end
                                            end
                                            else
                                            begin
                                                res_load    = 1'b0;
                                                state_next  = S_SCAN;
                                                pc_next     = pc_reg;
                                                scan_p_next = pc_plus;
                                                nest_next   = '0;
                                                prog_re     = 1'b1;
                                            end
                                        end
                                        bfi_pkg::OP_CLOSE:
                                        begin
                                            if (depth_reg == '0)
                                            begin
                                                run_status_next = bfi_pkg::ST_UNMATCHED;
                                                pc_next         = pc_reg;
                                            end
                                            else if (tape_rdata != 8'd0)
                                            begin
                                                pc_next = stack_rdata + PC_W'(1);
                                            end
                                            else
                                            begin
                                                depth_next = depth_reg - SD_W'(1);
                                            end
                                        end
                                        bfi_pkg::OP_RIGHT:
                                        begin
                                            if (32'(dp_reg) + 32'd1 >= 32'(TAPE_DEPTH))
                                            begin
                                                run_status_next = bfi_pkg::ST_RANGE;
                                                pc_next         = pc_reg;
                                            end
                                            else
                                            begin
                                                dp_next = dp_reg + DP_W'(1);
                                            end
                                        end
                                        bfi_pkg::OP_LEFT:
                                        begin
                                            if (dp_reg == '0)
                                            begin
                                                run_status_next = bfi_pkg::ST_RANGE;
                                                pc_next         = pc_reg;
                                            end
                                            else
                                            begin
                                                dp_next = dp_reg - DP_W'(1);
                                            end
                                        end
                                        bfi_pkg::OP_INC:
                                        begin
                                            exec_tape_we  = 1'b1;
                                            exec_tape_val = tape_rdata + 8'd1;
                                        end
                                        bfi_pkg::OP_DEC:
                                        begin
                                            exec_tape_we  = 1'b1;
                                            exec_tape_val = tape_rdata - 8'd1;
                                        end
                                        bfi_pkg::OP_IN:
                                        begin
                                            exec_tape_we        = 1'b1;
                                            exec_tape_val       = din_reg;
                                            res_data.input_used = 1'b1;
                                        end
                                        bfi_pkg::OP_OUT:
                                        begin
                                            res_data.out_valid = 1'b1;
                                            res_data.out_byte  = tape_rdata;
                                        end
                                        default:
                                        begin
                                        end
                                    endcase
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                priority if ((scan_p_reg >= prog_end) || (prog_rdata == 8'd0))
                begin
                    if (res_free)
                    begin
                        pc_next         = scan_p_reg;
                        run_status_next = bfi_pkg::ST_DONE;
                        res_load        = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else if ((prog_rdata == bfi_pkg::OP_CLOSE) && (nest_reg == '0))
                begin
                    if (res_free)
                    begin
                        pc_next    = scan_p_reg + PC_W'(1);
                        res_load   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    if (prog_rdata == bfi_pkg::OP_OPEN)
                    begin
                        nest_next = nest_reg + PC_W'(1);
                    end
                    else if (prog_rdata == bfi_pkg::OP_CLOSE)
                    begin
                        nest_next = nest_reg - PC_W'(1);
                    end
                    scan_p_next = scan_p_reg + PC_W'(1);
                    prog_re     = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res_data.status = run_status_next;

        if (res_load)
        begin
            res_valid_next = 1'b1;
            res_next       = res_data;
        end
        else
        begin
            res_valid_next = res_valid_reg && !result_ready;
            res_next       = res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pc_reg         <= '0;
            dp_reg         <= '0;
            depth_reg      <= '0;
            run_status_reg <= bfi_pkg::ST_RUN;
            len_reg        <= '0;
            act_reg        <= bfi_pkg::ACT_LOAD;
            din_reg        <= '0;
            scan_p_reg     <= '0;
            nest_reg       <= '0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            res_valid_reg  <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pc_reg         <= pc_next;
            dp_reg         <= dp_next;
            depth_reg      <= depth_next;
            run_status_reg <= run_status_next;
            len_reg        <= len_next;
            act_reg        <= act_next;
            din_reg        <= din_next;
            scan_p_reg     <= scan_p_next;
            nest_reg       <= nest_next;
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            res_valid_reg  <= res_valid_next;
            res_reg        <= res_next;
        end
    end

    assign prog_we    = in_fire && (action == bfi_pkg::ACT_LOAD)
                        && ({21'd0, load_address} < 32'(PROGRAM_DEPTH));
    assign prog_waddr = PA_W'(load_address);
    assign prog_wdata = data_byte;
    assign prog_raddr = (state_reg == S_IDLE) ? PA_W'(pc_reg) : PA_W'(scan_p_next);

    assign tape_re    = step_fire;
    assign tape_raddr = dp_reg;
    assign tape_we    = clr_active_reg || exec_tape_we;
    assign tape_waddr = clr_active_reg ? clr_addr_reg : dp_reg;
    assign tape_wdata = clr_active_reg ? 8'd0 : exec_tape_val;

    assign stack_re    = step_fire;
    assign stack_raddr = SA_W'(depth_reg - SD_W'(1));
    assign stack_waddr = SA_W'(depth_reg);
    assign stack_wdata = pc_reg;

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// File: rtl/brainfuck_interpreter_core.sv
// Items are accepted only in the idle state; a transfer moves the sequencer to its exec
// state, which reads then writes the tape RAM and loads the registered result once the
// result slot is free, so a new item waits for the last one. A '[' on a zero cell first
// scans the program bytes to its match or the program end. After a restart the tape is
// cleared one entry a cycle, input held off; the same clearing pass runs after reset.
// Reset (rst_n, async, active low) zeroes pc, pointer, stack depth, status, length.
// ----------------------------------------------------------------------------
// brainfuck_interpreter_core
// Brainfuck machine with program, tape and loop stack held in synchronous RAMs,
// driven by a read-modify-write instruction sequencer.
// ----------------------------------------------------------------------------
module brainfuck_interpreter_core #(
    parameter int PROGRAM_DEPTH = 2048,
    parameter int TAPE_DEPTH    = 1024,
    parameter int STACK_DEPTH   = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [10:0] load_address,
    input  logic [7:0]  data_byte,
    input  logic        cfg_wen,
    input  logic [11:0] cfg_wdata,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        out_valid,
    output logic [7:0]  out_byte,
    output logic        input_used,
    output logic [2:0]  status
);

    localparam int PA_W = $clog2(PROGRAM_DEPTH);
    localparam int PC_W = $clog2(PROGRAM_DEPTH + 1);
    localparam int DP_W = $clog2(TAPE_DEPTH);
    localparam int SA_W = $clog2(STACK_DEPTH);
    localparam int SD_W = $clog2(STACK_DEPTH + 1);

    bfi_pkg::result_t  res;

    logic              prog_we;
    logic [PA_W-1:0]   prog_waddr;
    logic [7:0]        prog_wdata;
    logic              prog_re;
    logic [PA_W-1:0]   prog_raddr;
    logic [7:0]        prog_rdata;
    logic              tape_we;
    logic [DP_W-1:0]   tape_waddr;
    logic [7:0]        tape_wdata;
    logic              tape_re;
    logic [DP_W-1:0]   tape_raddr;
    logic [7:0]        tape_rdata;
    logic              stack_we;
    logic [SA_W-1:0]   stack_waddr;
    logic [PC_W-1:0]   stack_wdata;
    logic              stack_re;
    logic [SA_W-1:0]   stack_raddr;
    logic [PC_W-1:0]   stack_rdata;

    bfi_seq #(
        .PROGRAM_DEPTH (PROGRAM_DEPTH),
        .TAPE_DEPTH    (TAPE_DEPTH),
        .STACK_DEPTH   (STACK_DEPTH),
        .PA_W          (PA_W),
        .PC_W          (PC_W),
        .DP_W          (DP_W),
        .SA_W          (SA_W),
        .SD_W          (SD_W)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .load_address (load_address),
        .data_byte    (data_byte),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (res),
        .prog_we      (prog_we),
        .prog_waddr   (prog_waddr),
        .prog_wdata   (prog_wdata),
        .prog_re      (prog_re),
        .prog_raddr   (prog_raddr),
        .prog_rdata   (prog_rdata),
        .tape_we      (tape_we),
        .tape_waddr   (tape_waddr),
        .tape_wdata   (tape_wdata),
        .tape_re      (tape_re),
        .tape_raddr   (tape_raddr),
        .tape_rdata   (tape_rdata),
        .stack_we     (stack_we),
        .stack_waddr  (stack_waddr),
        .stack_wdata  (stack_wdata),
        .stack_re     (stack_re),
        .stack_raddr  (stack_raddr),
        .stack_rdata  (stack_rdata)
    );

    bfi_ram #(
        .WIDTH (8),
        .DEPTH (PROGRAM_DEPTH),
        .AW    (PA_W)
    ) u_prog_ram (
        .clk   (clk),
        .we    (prog_we),
        .waddr (prog_waddr),
        .wdata (prog_wdata),
        .re    (prog_re),
        .raddr (prog_raddr),
        .rdata (prog_rdata)
    );

    bfi_ram #(
        .WIDTH (8),
        .DEPTH (TAPE_DEPTH),
        .AW    (DP_W)
    ) u_tape_ram (
        .clk   (clk),
        .we    (tape_we),
        .waddr (tape_waddr),
        .wdata (tape_wdata),
        .re    (tape_re),
        .raddr (tape_raddr),
        .rdata (tape_rdata)
    );

    bfi_ram #(
        .WIDTH (PC_W),
        .DEPTH (STACK_DEPTH),
        .AW    (SA_W)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .re    (stack_re),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    assign out_valid  = res.out_valid;
    assign out_byte   = res.out_byte;
    assign input_used = res.input_used;
    assign status     = res.status;

endmodule

// File: rtl/bfi_checker.sv
// ----------------------------------------------------------------------------
// bfi_checker
// Port-level checks of the interpreter core: result hold under stall and
// consistency of the fields of each result transfer.
// ----------------------------------------------------------------------------
module bfi_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       result_valid,
    input logic       result_ready,
    input logic       out_valid,
    input logic [7:0] out_byte,
    input logic       input_used,
    input logic [2:0] status
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid
            && $stable({out_valid, out_byte, input_used, status}))
        else $error("result changed while stalled");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !out_valid |-> out_byte == 8'd0)
        else $error("out_byte nonzero without emit");

    a_io_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(out_valid && input_used))
        else $error("emit and input use in one transfer");

    a_io_running: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (out_valid || input_used)
            |-> status == 3'(bfi_pkg::ST_RUN))
        else $error("I/O transfer with halted status");

endmodule

bind brainfuck_interpreter_core bfi_checker u_bfi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_valid    (out_valid),
    .out_byte     (out_byte),
    .input_used   (input_used),
    .status       (status)
);

// File: tb/sv/brainfuck_interpreter_core_tb.sv
// ----------------------------------------------------------------------------
// brainfuck_interpreter_core_tb
// Self-checking bench for the Brainfuck interpreter core. A queue of load,
// restart and step transfers feeds a valid/ready driver; an item-level model
// of the machine predicts one result per accepted transfer, and a monitor
// compares each result field by field. The run covers short directed
// programs, random programs with noise transfers, a step off the tape start
// and a skipped loop followed by an unmatched close, under several idle/stall
// mixes.
// ----------------------------------------------------------------------------
module brainfuck_interpreter_core_tb;

    localparam int PROG_N         = 2048;
    localparam int TAPE_N         = 1024;
    localparam int STACK_N        = 1024;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  act;
        logic [10:0] addr;
        logic [7:0]  data;
    } bf_item_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [1:0]  action       = bfi_pkg::ACT_LOAD;
    logic [10:0] load_address = '0;
    logic [7:0]  data_byte    = '0;
    logic        cfg_wen      = 1'b0;
    logic [11:0] cfg_wdata    = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        input_used;
    logic [2:0]  status;

    bf_item_t          pending_items[$];
    bfi_pkg::result_t  expected_results[$];
    logic [7:0]        code_buf[$];
    bf_item_t          next_item;
    bfi_pkg::result_t  expected_now;

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int mismatches    = 0;
    int idle_cycles   = 0;
    int queued_items  = 0;
    int prog_top      = 0;
    bit in_fire       = 1'b0;
    bit out_fire      = 1'b0;

    logic [7:0]       bf_program[PROG_N];
    logic [7:0]       bf_tape[TAPE_N];
    int unsigned      bf_stack[STACK_N];
    int unsigned      bf_pc;
    int unsigned      bf_ptr;
    int unsigned      bf_depth;
    int unsigned      bf_length;
    bfi_pkg::status_t bf_status;

    brainfuck_interpreter_core #(
        .PROGRAM_DEPTH (PROG_N),
        .TAPE_DEPTH    (TAPE_N),
        .STACK_DEPTH   (STACK_N)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .load_address (load_address),
        .data_byte    (data_byte),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_valid    (out_valid),
        .out_byte     (out_byte),
        .input_used   (input_used),
        .status       (status)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void clear_machine();
        foreach (bf_tape[i])
        begin
            bf_tape[i] = '0;
        end
        bf_pc     = 0;
        bf_ptr    = 0;
        bf_depth  = 0;
        bf_status = bfi_pkg::ST_RUN;
    endfunction

    function automatic bit past_end(int unsigned p);
        int unsigned lim;
        lim = (bf_length < PROG_N) ? bf_length : PROG_N;
        return (p >= lim) || (bf_program[p] == 8'h00);
    endfunction

    function automatic bfi_pkg::result_t interpret_item(bf_item_t it);
        bfi_pkg::result_t r;
        logic [7:0]       op;
        logic [7:0]       cur_cell;
        int unsigned      nxt;
        int unsigned      p;
        int unsigned      nest;
        bit               halt;
        bit               scan;
        r = '0;
        if (it.act == bfi_pkg::ACT_LOAD)
        begin
            bf_program[it.addr] = it.data;
        end
        else if (it.act == bfi_pkg::ACT_RESTART)
        begin
            clear_machine();
        end
        else if (it.act == bfi_pkg::ACT_STEP && bf_status == bfi_pkg::ST_RUN)
        begin
            if (past_end(bf_pc))
            begin
                bf_status = bfi_pkg::ST_DONE;
            end
            else
            begin
                op       = bf_program[bf_pc];
                cur_cell = bf_tape[bf_ptr];
                nxt      = bf_pc + 1;
                halt     = 1'b0;
                case (op)
                    bfi_pkg::OP_OPEN:
                    begin
                        if (cur_cell != 0)
                        begin
                            if (bf_depth < STACK_N)
                                bf_stack[bf_depth] = bf_pc;
                            bf_depth++;
                            if (bf_depth >= STACK_N)
                            begin
                                bf_status = bfi_pkg::ST_OVERFLOW;
                                halt      = 1'b1;
                            end
                        end
                        else
                        begin
                            // scan forward to the matching close
                            p    = bf_pc + 1;
                            nest = 0;
                            scan = 1'b1;
                            while (scan)
                            begin
                                if (past_end(p))
                                begin
                                    bf_pc     = p;
                                    bf_status = bfi_pkg::ST_DONE;
                                    halt      = 1'b1;
                                    scan      = 1'b0;
                                end
                                else if (bf_program[p] == bfi_pkg::OP_CLOSE && nest == 0)
                                begin
                                    scan = 1'b0;
                                end
                                else
                                begin
                                    if (bf_program[p] == bfi_pkg::OP_OPEN)
                                        nest++;
                                    else if (bf_program[p] == bfi_pkg::OP_CLOSE)
                                        nest--;
                                    p++;
                                end
                            end
                            if (!halt)
                                nxt = p + 1;
                        end
                    end
                    bfi_pkg::OP_CLOSE:
                    begin
                        if (bf_depth == 0)
                        begin
                            bf_status = bfi_pkg::ST_UNMATCHED;
                            halt      = 1'b1;
                        end
                        else if (cur_cell != 0)
                        begin
                            nxt = bf_stack[bf_depth - 1] + 1;
                        end
                        else
                        begin
                            bf_depth--;
                        end
                    end
                    bfi_pkg::OP_RIGHT:
                    begin
                        if (bf_ptr + 1 >= TAPE_N)
                        begin
                            bf_status = bfi_pkg::ST_RANGE;
                            halt      = 1'b1;
                        end
                        else
                        begin
                            bf_ptr++;
                        end
                    end
                    bfi_pkg::OP_LEFT:
                    begin
                        if (bf_ptr == 0)
                        begin
                            bf_status = bfi_pkg::ST_RANGE;
                            halt      = 1'b1;
                        end
                        else
                        begin
                            bf_ptr--;
                        end
                    end
                    bfi_pkg::OP_INC: bf_tape[bf_ptr] = cur_cell + 8'd1;
                    bfi_pkg::OP_DEC: bf_tape[bf_ptr] = cur_cell - 8'd1;
                    bfi_pkg::OP_IN:
                    begin
                        bf_tape[bf_ptr] = it.data;
                        r.input_used    = 1'b1;
                    end
                    bfi_pkg::OP_OUT:
                    begin
                        r.out_valid = 1'b1;
                        r.out_byte  = cur_cell;
                    end
                    default: ;
                endcase
                if (!halt)
                    bf_pc = nxt;
            end
        end
        r.status = bf_status;
        return r;
    endfunction

    // input driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_fire)
        begin
            if (pending_items.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                next_item = pending_items.pop_front();
                action       <= next_item.act;
                load_address <= next_item.addr;
                data_byte    <= next_item.data;
                in_valid     <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // result ready driver
    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // transfer monitor and result check
    always @(posedge clk)
    begin
        in_fire  = rst_n && in_valid && in_ready;
        out_fire = rst_n && result_valid && result_ready;
        if (in_fire)
            expected_results.push_back(interpret_item({action, load_address, data_byte}));
        if (out_fire)
        begin
            if (expected_results.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result: %0d/%02h/%0d/%0d",
                             out_valid, out_byte, input_used, status);
                mismatches++;
            end
            else
            begin
                expected_now = expected_results.pop_front();
                if (out_valid !== expected_now.out_valid || out_byte !== expected_now.out_byte ||
                    input_used !== expected_now.input_used || status !== expected_now.status)
                begin
                    if (mismatches < 10)
                        $display("mismatch: expected %0d/%02h/%0d/%0d got %0d/%02h/%0d/%0d",
                                 expected_now.out_valid, expected_now.out_byte,
                                 expected_now.input_used, expected_now.status,
                                 out_valid, out_byte, input_used, status);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || in_fire || out_fire)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("brainfuck_interpreter_core regression: fail");
            $finish;
        end
    end

    task automatic push_item(logic [1:0] a, logic [10:0] ad, logic [7:0] d);
        pending_items.push_back({a, ad, d});
        queued_items++;
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    task automatic write_length(int v);
        drain();
        repeat (4) @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= 12'(v);
        @(negedge clk);
        cfg_wen   <= 1'b0;
        bf_length = v;
    endtask

    // the byte after the program stays zero, so no unwritten byte is ever reached
    task automatic load_code();
        foreach (code_buf[i])
        begin
            push_item(bfi_pkg::ACT_LOAD, 11'(i), code_buf[i]);
        end
        push_item(bfi_pkg::ACT_LOAD, 11'(code_buf.size()), 8'h00);
        prog_top = code_buf.size();
    endtask

    task automatic build_random_code(int n);
        int unclosed;
        int r;
        code_buf.delete();
        unclosed = 0;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            if (r < 12)
            begin
                code_buf.push_back(bfi_pkg::OP_OPEN);
                unclosed++;
            end
            else if (r < 22)
            begin
                if (unclosed > 0 || r >= 20)
                begin
                    code_buf.push_back(bfi_pkg::OP_CLOSE);
                    if (unclosed > 0)
                        unclosed--;
                end
                else
                begin
                    code_buf.push_back(bfi_pkg::OP_INC);
                end
            end
            else if (r < 38)
                code_buf.push_back(bfi_pkg::OP_INC);
            else if (r < 52)
                code_buf.push_back(bfi_pkg::OP_DEC);
            else if (r < 62)
                code_buf.push_back(bfi_pkg::OP_RIGHT);
            else if (r < 68)
                code_buf.push_back(bfi_pkg::OP_LEFT);
            else if (r < 78)
                code_buf.push_back(bfi_pkg::OP_IN);
            else if (r < 92)
                code_buf.push_back(bfi_pkg::OP_OUT);
            else
                code_buf.push_back(8'($urandom_range(255, 1)));
        end
        while (unclosed > 0)
        begin
            if ($urandom_range(3) != 0)
                code_buf.push_back(bfi_pkg::OP_CLOSE);
            unclosed--;
        end
    endtask

    task automatic run_steps(int n, int noise_pct);
        int a;
        int r;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(99) < noise_pct)
            begin
                r = $urandom_range(9);
                if (r < 6)
                begin
                    a = $urandom_range(PROG_N - 1);
                    push_item(bfi_pkg::ACT_LOAD, 11'(a),
                              (a == prog_top) ? 8'h00 : 8'($urandom));
                end
                else if (r < 9)
                begin
                    push_item(ACT_UNUSED, 11'($urandom), 8'($urandom));
                end
                else
                begin
                    push_item(bfi_pkg::ACT_RESTART, 11'($urandom), 8'($urandom));
                end
            end
            push_item(bfi_pkg::ACT_STEP, 11'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        int runs;
        int n;
        int pick;
        clear_machine();
        bf_length = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // length is zero out of reset: the first step finishes at once
        push_item(bfi_pkg::ACT_STEP, 11'h000, 8'hFF);
        write_length(PROG_N);
        code_buf = '{bfi_pkg::OP_IN, bfi_pkg::OP_OUT, bfi_pkg::OP_OPEN, bfi_pkg::OP_DEC,
                     bfi_pkg::OP_CLOSE, bfi_pkg::OP_OPEN, bfi_pkg::OP_OUT,
                     bfi_pkg::OP_CLOSE, bfi_pkg::OP_LEFT};
        load_code();
        push_item(bfi_pkg::ACT_RESTART, 11'h7FF, 8'h00);
        push_item(bfi_pkg::ACT_STEP, 11'h7FF, 8'h01);
        repeat (7) push_item(bfi_pkg::ACT_STEP, 11'h000, 8'h00);
        push_item(ACT_UNUSED, 11'h7FF, 8'hFF);
        push_item(bfi_pkg::ACT_LOAD, 11'h000, bfi_pkg::OP_CLOSE);
        push_item(bfi_pkg::ACT_RESTART, 11'h000, 8'hFF);
        push_item(bfi_pkg::ACT_STEP, 11'h000, 8'hFF);

        runs = 0;
        while (queued_items < 1500)
        begin
            case (runs % 4)
                0:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct  = 50;
                    snk_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 50;
                end
                default:
                begin
                    src_idle_pct  = 21;
                    snk_stall_pct = 21;
                end
            endcase
            if (runs == 2 || runs == 9)
                hold_request = 300;
            if (runs == 5)
            begin
                // step left off the tape start
                write_length(PROG_N);
                code_buf = '{bfi_pkg::OP_RIGHT, bfi_pkg::OP_LEFT, bfi_pkg::OP_LEFT,
                             bfi_pkg::OP_OUT};
                load_code();
                push_item(bfi_pkg::ACT_RESTART, 11'($urandom), 8'($urandom));
                run_steps(8, 0);
            end
            else if (runs == 7)
            begin
                // skip a loop on a zero cell, then close with no open loop
                write_length(PROG_N);
                code_buf = '{bfi_pkg::OP_OPEN, bfi_pkg::OP_INC, bfi_pkg::OP_CLOSE,
                             bfi_pkg::OP_CLOSE};
                load_code();
                push_item(bfi_pkg::ACT_RESTART, 11'($urandom), 8'($urandom));
                run_steps(6, 0);
            end
            else
            begin
                if (runs % 3 == 0)
                begin
                    pick = $urandom_range(7);
                    if (pick == 0)
                        write_length(0);
                    else if (pick < 3)
                        write_length(PROG_N);
                    else if (pick < 5)
                        write_length($urandom_range(40, 1));
                    else
                        write_length($urandom_range(PROG_N));
                end
                n = ($urandom_range(7) == 0) ? $urandom_range(300, 40) : $urandom_range(40, 1);
                build_random_code(n);
                load_code();
                push_item(bfi_pkg::ACT_RESTART, 11'($urandom), 8'($urandom));
                run_steps($urandom_range(3 * n + 10, n), 6);
            end
            runs++;
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("brainfuck_interpreter_core regression: pass");
        else
            $display("brainfuck_interpreter_core regression: fail");
        $finish;
    end

endmodule
